// ===== hw/rtl/cslc_pkg.sv =====
// Shared types, codes and defaults for the cursor sequence list core.
package cslc_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // Operation codes carried in a command transaction
  typedef enum logic [2:0] {
    FN_START      = 3'd0,
    FN_ADVANCE    = 3'd1,
    FN_INSERT     = 3'd2,
    FN_ATTACH     = 3'd3,
    FN_REMOVE_CUR = 3'd4,
    FN_REMOVE_ALL = 3'd5,
    FN_READ       = 3'd6
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOCUR = 2'd2
  } status_t;

  // Per-cycle shift command broadcast along the cell chain
  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_UP   = 2'd1,
    SH_DOWN = 2'd2
  } shift_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic        has_current;
    logic [31:0] current_value;
    logic [4:0]  cursor_pos;
    logic [5:0]  item_count;
  } res_t;

endpackage

// ===== hw/rtl/cslc_cell.sv =====
// One storage cell of the list chain: holds one entry, loads or takes a neighbor.
module cslc_cell #(
  parameter int VALUE_BITS = cslc_pkg::VALUE_BITS_DEF,
  parameter int CUR_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cslc_pkg::shift_t      kind,
  input  logic [CUR_W-1:0]      pos,
  input  logic [VALUE_BITS-1:0] load_value,
  input  logic [VALUE_BITS-1:0] left,
  input  logic [VALUE_BITS-1:0] right,
  output logic [VALUE_BITS-1:0] q
);
  import cslc_pkg::*;

  localparam logic [CUR_W-1:0] IDX = CUR_W'(INDEX);

  always_ff @(posedge clk) begin
    case (kind)
      SH_UP: begin
        // open a gap at pos: load there, move everything above up by one
        if (IDX == pos) begin
          q <= load_value;
        end else if (IDX > pos) begin
          q <= left;
        end
      end
      SH_DOWN: begin
        // close the gap at pos
        if (IDX >= pos) begin
          q <= right;
        end
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

// ===== hw/rtl/cursor_sequence_list_core.sv =====
// Top level of the cursor sequence list core: control, cell chain and result register.
// A command transaction updates the cell chain and list state when it is accepted; its result
// is then registered from them once the result output is free. A new command is held off
// until the result of the last one has been loaded into the result register.
// Reset (rst, synchronous, active high) empties the list, puts the cursor on slot 0
// and drops any pending result; stored entries are not cleared.
module cursor_sequence_list_core #(
  parameter int CAPACITY   = cslc_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = cslc_pkg::VALUE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  cslc_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output cslc_pkg::res_t res
);
  import cslc_pkg::*;

  localparam int CUR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
  localparam logic [CUR_W-1:0] ONE_CUR = CUR_W'(1);

  // List state
  logic [CNT_W-1:0] count;
  logic [CUR_W-1:0] cursor;
  logic             cursor_none;
  logic [CNT_W-1:0] count_next;
  logic [CUR_W-1:0] cursor_next;
  logic             cursor_none_next;

  // A result is owed for the last accepted transaction
  logic    pending;
  status_t status_q;
  status_t status_next;

  // Chain command
  shift_t           shift_kind;
  logic [CUR_W-1:0] shift_pos;
  logic [VALUE_BITS-1:0] load_value;
  logic [VALUE_BITS-1:0] cell_q [CAPACITY];

  logic             cmd_accept;
  logic             res_load;
  logic             has_item;
  logic             full;
  logic [CUR_W-1:0] base;
  logic [CUR_W-1:0] last_pos;
  logic [CNT_W-1:0] count_dec;

  // Hold new commands while a result is still owed
  assign cmd_stall  = pending;
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign res_load   = pending && (!res_valid || !res_stall);

  assign has_item   = !cursor_none && (CNT_W'(cursor) < count);
  assign full       = (count == CAP_CNT);
  assign base       = has_item ? cursor : '0;
  assign last_pos   = CUR_W'(count - ONE_CNT);
  assign count_dec  = count - ONE_CNT;
  assign load_value = VALUE_BITS'(cmd.value);

  // Next state and chain command for the operation
  always_comb begin
    count_next       = count;
    cursor_next      = cursor;
    cursor_none_next = cursor_none;
    status_next      = ST_OK;
    shift_kind       = SH_NONE;
    shift_pos        = cursor;
    case (cmd.func)
      FN_START: begin
        cursor_next      = '0;
        cursor_none_next = 1'b0;
      end
      FN_ADVANCE: begin
        if (has_item) begin
          // stay on the last item
          if (CNT_W'(cursor) < count_dec) begin
            cursor_next = cursor + ONE_CUR;
          end
        end else begin
          status_next = ST_NOCUR;
          if (count == '0) begin
            cursor_none_next = 1'b1;
          end else begin
            cursor_next      = last_pos;
            cursor_none_next = 1'b0;
          end
        end
      end
      FN_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          shift_kind       = SH_UP;
          shift_pos        = base;
          cursor_next      = base;
          cursor_none_next = 1'b0;
          count_next       = count + ONE_CNT;
        end
      end
      FN_ATTACH: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (count == '0) begin
          // empty list: new item lands on slot 0 with the cursor on it
          shift_kind       = SH_UP;
          shift_pos        = '0;
          cursor_next      = '0;
          cursor_none_next = 1'b0;
          count_next       = ONE_CNT;
        end else begin
          shift_kind       = SH_UP;
          shift_pos        = base + ONE_CUR;
          cursor_next      = base + ONE_CUR;
          cursor_none_next = 1'b0;
          count_next       = count + ONE_CNT;
        end
      end
      FN_REMOVE_CUR: begin
        if (!has_item) begin
          status_next = ST_NOCUR;
        end else begin
          shift_kind = SH_DOWN;
          shift_pos  = cursor;
          count_next = count_dec;
          // cursor fell off the end: move to the new last item, or nowhere
          if (CNT_W'(cursor) == count_dec) begin
            if (count_dec == '0) begin
              cursor_none_next = 1'b1;
            end else begin
              cursor_next = CUR_W'(count_dec - ONE_CNT);
            end
          end
        end
      end
      FN_REMOVE_ALL: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Cell chain: each cell sees its lower and upper neighbor
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_BITS-1:0] left;
    logic [VALUE_BITS-1:0] right;
    if (g == 0) begin : g_first
      assign left = cell_q[g];
    end else begin : g_mid_lo
      assign left = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = cell_q[g];
    end else begin : g_mid_hi
      assign right = cell_q[g+1];
    end
    cslc_cell #(
      .VALUE_BITS (VALUE_BITS),
      .CUR_W      (CUR_W),
      .INDEX      (g)
    ) u_cell (
      .clk        (clk),
      .kind       (cmd_accept ? shift_kind : SH_NONE),
      .pos        (shift_pos),
      .load_value (load_value),
      .left       (left),
      .right      (right),
      .q          (cell_q[g])
    );
  end

  // Control state and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      cursor      <= '0;
      cursor_none <= 1'b0;
      pending     <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (cmd_accept) begin
        count       <= count_next;
        cursor      <= cursor_next;
        cursor_none <= cursor_none_next;
        pending     <= 1'b1;
      end
      if (res_load) begin
        pending   <= 1'b0;
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload: read the current item out of the chain after the update
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      status_q <= status_next;
    end
    if (res_load) begin
      res.status        <= status_q;
      res.has_current   <= has_item;
      res.current_value <= has_item ? 32'(cell_q[cursor]) : 32'd0;
      res.cursor_pos    <= has_item ? 5'(cursor) : 5'd0;
      res.item_count    <= 6'(count);
    end
  end

endmodule

// ===== hw/rtl/cslc_checker.sv =====
// Port-level checker for the cursor sequence list core, bound to the top level.
module cslc_checker #(
  parameter int CAPACITY = cslc_pkg::CAPACITY_DEF
) (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input logic           res_valid,
  input logic           res_stall,
  input cslc_pkg::res_t res
);
  import cslc_pkg::*;

  // A stalled result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

  // No current item means cursor fields read as zero
  a_no_cur_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.has_current |-> res.current_value == 32'd0 && res.cursor_pos == 5'd0)
    else $error("cursor fields not zero without a current item");

  // A full rejection reports a full list
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_FULL |-> res.item_count == 6'(CAPACITY))
    else $error("full status with list not full");

  // A fresh result always follows an accepted command transaction
  a_res_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(cmd_valid && !cmd_stall, 2))
    else $error("result without a command transaction");

endmodule

bind cursor_sequence_list_core cslc_checker #(.CAPACITY(CAPACITY)) u_cslc_checker (.*);

// ===== verif/cursor_sequence_list_core_test.sv =====
// Self-checking testbench for the cursor sequence list core: random operations against a list predictor.
module cursor_sequence_list_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cslc_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned SHOWN_FAULTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  cursor_sequence_list_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Commands waiting to go out; the head is the one on the bus while cmd_valid is high.
  cmd_t ops_to_send[$];
  // Status reports the list should produce, oldest first.
  res_t reports_due[$];

  // Traffic knobs, written by the sequencer at the falling edge only.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit sender_hold = 1'b0;
  int unsigned long_hold_reqs = 0;

  // Receiver-owned hold-off state.
  int unsigned long_hold_seen = 0;
  int unsigned hold_left = 0;

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Shadow copy of the list: stored values, length and cursor.
  logic [31:0] list_vals[CAP];
  int unsigned list_len = 0;
  int unsigned cur_slot = 0;
  bit cur_gone = 1'b0;

  // A current item exists only when the cursor points inside the stored range.
  function automatic bit on_current();
    return !cur_gone && cur_slot < list_len;
  endfunction

  // Shift slots pos..len-1 up by one to open a hole at pos.
  function automatic void open_slot(int unsigned pos);
    for (int unsigned i = list_len; i > pos; i--) list_vals[i] = list_vals[i - 1];
  endfunction

  // Apply one list operation to the shadow copy and build the status report it yields.
  function automatic res_t apply_list_op(cmd_t op);
    status_t st;
    res_t rep;
    bit has;
    st = ST_OK;
    case (op.func)
      FN_START: begin
        cur_slot = 0;
        cur_gone = 1'b0;
      end
      FN_ADVANCE: begin
        if (on_current()) begin
          // stay on the last item
          if (cur_slot + 1 < list_len) cur_slot++;
        end else begin
          st = ST_NOCUR;
          if (list_len == 0) begin
            cur_gone = 1'b1;
          end else begin
            cur_slot = list_len - 1;
            cur_gone = 1'b0;
          end
        end
      end
      FN_INSERT: begin
        if (list_len >= CAP) begin
          st = ST_FULL;
        end else begin
          if (!on_current()) begin
            cur_slot = 0;
            cur_gone = 1'b0;
          end
          open_slot(cur_slot);
          list_vals[cur_slot] = op.value;
          list_len++;
        end
      end
      FN_ATTACH: begin
        if (list_len >= CAP) begin
          st = ST_FULL;
        end else if (list_len == 0) begin
          // empty list: new item lands in slot 0 and the cursor stays on it
          list_vals[0] = op.value;
          cur_slot = 0;
          cur_gone = 1'b0;
          list_len = 1;
        end else begin
          if (!on_current()) begin
            cur_slot = 0;
            cur_gone = 1'b0;
          end
          open_slot(cur_slot + 1);
          list_vals[cur_slot + 1] = op.value;
          list_len++;
          cur_slot++;
        end
      end
      FN_REMOVE_CUR: begin
        if (!on_current()) begin
          st = ST_NOCUR;
        end else begin
          for (int unsigned i = cur_slot; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
          list_len--;
          // cursor fell off the end: pull it back, or drop it on an emptied list
          if (cur_slot == list_len) begin
            if (list_len == 0) cur_gone = 1'b1;
            else cur_slot = list_len - 1;
          end
        end
      end
      FN_REMOVE_ALL: list_len = 0;
      default: ;
    endcase
    has = on_current();
    rep.status = st;
    rep.has_current = has;
    rep.current_value = has ? list_vals[cur_slot % CAP] : '0;
    rep.cursor_pos = has ? 5'(cur_slot) : '0;
    rep.item_count = 6'(list_len);
    return rep;
  endfunction

  task automatic log_fault(string msg);
    fail_count++;
    if (fail_count <= SHOWN_FAULTS) $display("FAULT @%0d: %s", cycle_count, msg);
  endtask

  // Driver: retire the accepted transaction, then hold, offer the next command, or idle.
  always @(posedge clk) begin : driver
    bit offer;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        reports_due.push_back(apply_list_op(cmd));
        ops_to_send.delete(0);
      end
      // a stalled command stays on the bus untouched
      if (!(cmd_valid && cmd_stall)) begin
        offer = ops_to_send.size() != 0 && !sender_hold &&
                $urandom_range(0, 99) >= send_idle_pct;
        if (offer) cmd <= ops_to_send[0];
        cmd_valid <= offer;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever the sequencer asks for one.
  always @(posedge clk) begin : receiver
    if (long_hold_reqs != long_hold_seen) begin
      long_hold_seen = long_hold_reqs;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= $urandom_range(0, 99) < recv_stall_pct;
    end
  end

  // Monitor: compare every accepted report with the oldest prediction.
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (reports_due.size() == 0) begin
        log_fault($sformatf("unexpected report %p", res));
      end else begin
        want = reports_due.pop_front();
        if (res.status !== want.status || res.has_current !== want.has_current ||
            res.current_value !== want.current_value ||
            res.cursor_pos !== want.cursor_pos || res.item_count !== want.item_count)
          log_fault($sformatf({"status %0d/%0d has_current %0b/%0b value %h/%h ",
                               "cursor %0d/%0d count %0d/%0d (expected/actual)"},
                              want.status, res.status, want.has_current, res.has_current,
                              want.current_value, res.current_value,
                              want.cursor_pos, res.cursor_pos,
                              want.item_count, res.item_count));
      end
    end
  end

  // Watchdog: abort a run that stops making progress.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_op(func_t f, logic [31:0] v);
    cmd_t c;
    c.func = f;
    c.value = v;
    ops_to_send.push_back(c);
  endtask

  // Mostly random values; zero and all-ones now and then.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Queue n random commands in runs: grow bursts that can reach a full list, walk-and-delete
  // runs that shrink it, plain random mixes, and clear-then-read runs.
  task automatic queue_random_ops(int unsigned n);
    int unsigned made, kind, run, steps;
    func_t f;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 9);
      steps = $urandom_range(0, 12);
      if (kind < 4) run = $urandom_range(8, 40);
      else if (kind < 6) run = steps + 1 + $urandom_range(1, 12);
      else run = $urandom_range(3, 14);
      for (int unsigned k = 0; k < run && made < n; k++) begin
        if (kind < 4) begin
          if ($urandom_range(0, 5) == 0) f = $urandom_range(0, 1) ? FN_ADVANCE : FN_START;
          else f = $urandom_range(0, 1) ? FN_INSERT : FN_ATTACH;
        end else if (kind < 6) begin
          if (k == 0) f = FN_START;
          else if (k <= steps) f = FN_ADVANCE;
          else f = FN_REMOVE_CUR;
        end else if (kind < 9) begin
          f = func_t'(3'($urandom_range(0, 6)));
        end else begin
          f = (k == 0) ? FN_REMOVE_ALL : FN_READ;
        end
        push_op(f, pick_value());
        made++;
      end
    end
  endtask

  // Block until every queued command went out and every report came back.
  task automatic wait_all_done();
    while (ops_to_send.size() != 0 || reports_due.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned n);
    @(negedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    queue_random_ops(n);
    wait_all_done();
  endtask

  // Sequencer: reset, directed corner cases, then the random phases.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // corner cases, starting on an empty list
    push_op(FN_READ, '0);
    push_op(FN_ADVANCE, '0);          // no current item, cursor dropped
    push_op(FN_REMOVE_CUR, '0);       // nothing to remove
    push_op(FN_INSERT, '0);           // no current item: goes to the front
    push_op(FN_START, '1);
    push_op(FN_ATTACH, '1);           // after the current item
    push_op(FN_ADVANCE, '0);          // already on the last item
    push_op(FN_INSERT, 32'h1234_5678);
    push_op(FN_START, '0);
    push_op(FN_ADVANCE, '0);
    push_op(FN_ADVANCE, '0);
    push_op(FN_REMOVE_CUR, '0);       // last item: cursor moves back
    push_op(FN_REMOVE_ALL, '0);       // cursor left where it was
    push_op(FN_READ, '0);
    push_op(FN_ATTACH, 32'hA5A5_A5A5); // attach into an empty list
    push_op(FN_INSERT, 32'h5A5A_5A5A);
    push_op(FN_REMOVE_ALL, '0);
    push_op(FN_START, '0);            // start on an empty list is fine
    push_op(FN_INSERT, $urandom());
    push_op(FN_INSERT, $urandom());
    push_op(FN_INSERT, $urandom());
    push_op(FN_ADVANCE, '0);
    push_op(FN_REMOVE_CUR, '0);       // middle item: gap closes
    push_op(FN_REMOVE_CUR, '0);
    push_op(FN_REMOVE_CUR, '0);       // list emptied, cursor dropped
    wait_all_done();

    run_phase(0, 0, 90);

    // Back-pressure: hold the receiver off while commands keep coming, then pause
    // the sender until the list has answered everything.
    @(negedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random_ops(40);
    long_hold_reqs++;
    while (ops_to_send.size() > 20) @(negedge clk);
    sender_hold = 1'b1;
    while (reports_due.size() != 0 || cmd_valid) @(negedge clk);
    sender_hold = 1'b0;
    wait_all_done();

    run_phase(74, 0, 90);
    run_phase(0, 74, 90);
    run_phase(32, 32, 90);

    // let any stray report show up before judging
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (reports_due.size() != 0)
      log_fault($sformatf("%0d reports never arrived", reports_due.size()));
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== cursor_sequence_list_core.f =====
hw/rtl/cslc_pkg.sv
hw/rtl/cslc_cell.sv
hw/rtl/cursor_sequence_list_core.sv
hw/rtl/cslc_checker.sv
verif/cursor_sequence_list_core_test.sv
